// ===== design/dns_reply_answer_extractor_defines.svh =====
// Assertion macros for the DNS reply answer extractor.
// Used by the top level; no other dependencies.
`ifndef DNS_REPLY_ANSWER_EXTRACTOR_DEFINES_SVH
`define DNS_REPLY_ANSWER_EXTRACTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define DRE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DRE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DRE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/dre_pkg.sv =====
// Shared types and constants for the DNS reply answer extractor.
// No dependencies.
package dre_pkg;
    localparam int LengthBitsDefault = 16;
    localparam int HeaderBytes = 12;

    localparam logic [1:0] CfgFlagsMask     = 2'd0;
    localparam logic [1:0] CfgFlagsExpected = 2'd1;
    localparam logic [1:0] CfgMaxAddresses  = 2'd2;
    localparam logic [1:0] CfgNameLimit     = 2'd3;

    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusError    = 2'd1;
    localparam logic [1:0] StatusNone     = 2'd2;

    localparam logic KindRecord  = 1'b0;
    localparam logic KindSummary = 1'b1;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] address;
        logic [31:0] ttl;
        logic [1:0]  status;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    entry0;
        t_result    entry1;
    } t_push;
endpackage

// ===== design/dre_in_if.sv =====
// Input channel of the DNS reply answer extractor: one payload byte per beat.
// No dependencies.
interface dre_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic [15:0] payload_length;
    logic        reply_expected;
    modport source (output valid, payload_byte, first_byte, payload_length,
                    reply_expected, input ready);
    modport sink (input valid, payload_byte, first_byte, payload_length,
                  reply_expected, output ready);
endinterface

// ===== design/dre_out_if.sv =====
// Result channel of the DNS reply answer extractor.
// No dependencies.
interface dre_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] address;
    logic [31:0] ttl;
    logic [1:0]  status;
    logic        last;
    modport source (output valid, result_kind, address, ttl, status, last, input ready);
    modport sink (input valid, result_kind, address, ttl, status, last, output ready);
endinterface

// ===== design/dre_rfifo.sv =====
// Four-entry result queue taking up to two results a cycle.
// Depends on dre_pkg and dre_out_if.
module dre_rfifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dre_pkg::t_push    i_push,
    output logic              o_space2,
    dre_out_if.source         o_res
);
    dre_pkg::t_result r_mem [4];
    logic [1:0] r_head;
    logic [1:0] r_tail;
    logic [2:0] r_count;
    logic       pop;

    assign pop      = o_res.valid && o_res.ready;
    assign o_space2 = (r_count <= 3'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= r_head + 2'(pop);
            r_tail  <= r_tail + i_push.count;
            r_count <= r_count + 3'(i_push.count) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_tail] <= i_push.entry0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_tail + 2'd1] <= i_push.entry1;
        end
    end

    assign o_res.valid       = (r_count != 3'd0);
    assign o_res.result_kind = r_mem[r_head].result_kind;
    assign o_res.address     = r_mem[r_head].address;
    assign o_res.ttl         = r_mem[r_head].ttl;
    assign o_res.status      = r_mem[r_head].status;
    assign o_res.last        = r_mem[r_head].last;
endmodule

// ===== design/dns_reply_answer_extractor.sv =====
// DNS reply answer extractor: one payload byte a beat, results through a queue.
// Each result is registered into the queue as its byte is taken and is offered in order.
// Throughput: one byte per cycle; a byte is taken while two queue slots are free.
// Reset (synchronous, active low) idles the parser, clears the queue and loads
// the register defaults; bytes before a first byte are dropped.
// Depends on dre_pkg, dre_in_if, dre_out_if, dre_rfifo and the defines header.
`include "dns_reply_answer_extractor_defines.svh"
module dns_reply_answer_extractor #(
    parameter int LENGTH_BITS = dre_pkg::LengthBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    dre_in_if.sink      i_req,
    dre_out_if.source   o_res
);
    localparam int L = LENGTH_BITS;

    // Parser phases. The whole per-byte update is one combinational step from
    // the registered state, so every byte can follow the previous one directly.
    typedef enum logic [3:0] {
        PH_IDLE, PH_HDR, PH_NAME, PH_LABEL, PH_PTR, PH_QTAIL, PH_AFIX, PH_ADATA, PH_DONE
    } t_phase;

    typedef struct packed {
        t_phase phase;
        logic   set_err;
        logic   set_in_ans;
        logic   clr_addr;
    } t_nxt;

    // Decision at the start of each answer record.
    function automatic t_nxt f_next_answer(logic a_zero, logic full, logic after_zero);
        t_nxt r;
        r = '{phase: PH_DONE, set_err: 1'b0, set_in_ans: 1'b0, clr_addr: 1'b0};
        if (a_zero || full) begin
            r.phase = PH_DONE;
        end else if (after_zero) begin
            r.clr_addr = 1'b1;
        end else begin
            r.phase = PH_NAME;
        end
        return r;
    endfunction

    // Decision after the header or after each question.
    function automatic t_nxt f_next_question(logic q_zero, logic start_ok, logic a_zero,
                                             logic full, logic after_zero);
        t_nxt r;
        r = '{phase: PH_DONE, set_err: 1'b0, set_in_ans: 1'b0, clr_addr: 1'b0};
        if (q_zero) begin
            if (start_ok) begin
                r = f_next_answer(a_zero, full, after_zero);
                r.set_in_ans = 1'b1;
            end
        end else if (after_zero) begin
            r.set_err = 1'b1;
        end else begin
            r.phase = PH_NAME;
        end
        return r;
    endfunction

    // Configuration registers.
    logic [15:0] r_flags_mask;
    logic [15:0] r_flags_expected;
    logic [4:0]  r_max_addresses;
    logic [7:0]  r_name_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags_mask     <= 16'hFFFF;
            r_flags_expected <= 16'h0000;
            r_max_addresses  <= 5'd1;
            r_name_limit     <= 8'd254;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dre_pkg::CfgFlagsMask:     r_flags_mask     <= i_cfg_data;
                dre_pkg::CfgFlagsExpected: r_flags_expected <= i_cfg_data;
                dre_pkg::CfgMaxAddresses:  r_max_addresses  <= i_cfg_data[4:0];
                dre_pkg::CfgNameLimit:     r_name_limit     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Parser state.
    t_phase      r_phase, n_phase;
    logic [L-1:0] r_offset, n_offset;
    logic [L-1:0] r_total, n_total;
    logic        r_exp, n_exp;
    logic [15:0] r_flags, n_flags;
    logic [15:0] r_q_left, n_q_left;
    logic [15:0] r_a_left, n_a_left;
    logic [7:0]  r_label_left, n_label_left;
    logic [7:0]  r_name_len, n_name_len;
    logic [31:0] r_shift, n_shift;
    logic [15:0] r_rdl, n_rdl;
    logic [4:0]  r_stored, n_stored;
    logic [31:0] r_first_addr, n_first_addr;
    logic        r_err, n_err;
    logic        r_in_ans, n_in_ans;
    logic        r_first_q, n_first_q;
    logic        r_rec_is_a, n_rec_is_a;
    logic [3:0]  r_sub, n_sub;
    logic [15:0] r_rec_type, n_rec_type;
    logic [31:0] r_rec_ttl, n_rec_ttl;

    logic            space2;
    logic            acc;
    dre_pkg::t_push  push;
    logic            push_sum;
    logic [7:0]      b;
    logic [L-1:0]    rem;
    logic [L-1:0]    after;
    logic            after_zero;
    logic            start_ok;
    logic [9:0]      nl;
    logic [15:0]     len;
    t_nxt            nx;
    dre_pkg::t_result rec_res;
    dre_pkg::t_result sum_res;
    logic [1:0]      st;

    assign i_req.ready = space2;
    assign acc = i_req.valid && space2;
    assign b   = i_req.payload_byte;

    always_comb begin
        n_phase = r_phase; n_offset = r_offset; n_total = r_total; n_exp = r_exp;
        n_flags = r_flags; n_q_left = r_q_left; n_a_left = r_a_left;
        n_label_left = r_label_left; n_name_len = r_name_len; n_shift = r_shift;
        n_rdl = r_rdl; n_stored = r_stored; n_first_addr = r_first_addr; n_err = r_err;
        n_in_ans = r_in_ans; n_first_q = r_first_q; n_rec_is_a = r_rec_is_a;
        n_sub = r_sub; n_rec_type = r_rec_type; n_rec_ttl = r_rec_ttl;
        push = '0;
        push_sum = 1'b0;
        rem = '0; after = '0; after_zero = 1'b0; start_ok = 1'b0; nl = '0; len = '0;
        nx = '{phase: PH_DONE, set_err: 1'b0, set_in_ans: 1'b0, clr_addr: 1'b0};
        rec_res = '0;
        sum_res = '0;
        st = dre_pkg::StatusOk;

        if (acc) begin
            if (i_req.first_byte) begin
                // A new reply restarts everything; an unfinished one is dropped.
                n_total = i_req.payload_length[L-1:0];
                n_exp = i_req.reply_expected;
                n_offset = '0; n_flags = '0; n_q_left = '0; n_a_left = '0;
                n_label_left = '0; n_name_len = '0; n_shift = '0; n_rdl = '0;
                n_stored = '0; n_first_addr = '0; n_err = 1'b0; n_in_ans = 1'b0;
                n_first_q = 1'b1; n_rec_is_a = 1'b0; n_sub = '0; n_rec_type = '0;
                n_rec_ttl = '0;
                n_phase = PH_HDR;
                if (n_total < L'(dre_pkg::HeaderBytes)) begin
                    n_err = 1'b1;
                end
            end

            if (i_req.first_byte && n_total == '0) begin
                // Empty reply: error summary at once.
                n_phase = PH_IDLE;
                sum_res = '{result_kind: dre_pkg::KindSummary, address: 32'd0, ttl: 32'd0,
                            status: dre_pkg::StatusError, last: 1'b1};
                push_sum = 1'b1;
            end else if (n_phase != PH_IDLE && n_offset < n_total) begin
                rem = n_total - n_offset;
                after = rem - L'(1);
                after_zero = (after == '0);
                start_ok = n_exp && ((n_flags & r_flags_mask) == r_flags_expected);
                n_shift = {n_shift[23:0], b};

                case (n_phase)
                    PH_HDR: begin
                        if (n_err) begin
                            n_phase = PH_DONE;
                        end else if (n_offset == L'(3)) begin
                            n_flags = n_shift[15:0];
                        end else if (n_offset == L'(5)) begin
                            n_q_left = n_shift[15:0];
                        end else if (n_offset == L'(7)) begin
                            n_a_left = n_shift[15:0];
                        end else if (n_offset == L'(11)) begin
                            nx = f_next_question(n_q_left == '0, start_ok, n_a_left == '0,
                                                 n_stored >= r_max_addresses, after_zero);
                            n_phase = nx.phase;
                            if (nx.set_err) n_err = 1'b1;
                            if (nx.set_in_ans) n_in_ans = 1'b1;
                            if (nx.clr_addr) n_first_addr = '0;
                        end
                    end
                    PH_NAME: begin
                        if (b[7:6] == 2'b11) begin
                            // Compression pointer: needs at least two more bytes in the reply.
                            if (rem > L'(2)) begin
                                n_phase = PH_PTR;
                            end else begin
                                n_phase = PH_DONE;
                                if (n_in_ans) n_first_addr = '0; else n_err = 1'b1;
                            end
                        end else if (b == 8'd0) begin
                            if (!n_in_ans && n_first_q && n_name_len >= r_name_limit) begin
                                n_err = 1'b1;
                                n_phase = PH_DONE;
                            end else begin
                                n_sub = '0;
                                n_shift = '0;
                                if (!n_in_ans) begin
                                    if (after < L'(4)) begin
                                        n_err = 1'b1;
                                        n_phase = PH_DONE;
                                    end else begin
                                        n_phase = PH_QTAIL;
                                    end
                                end else if (after < L'(10)) begin
                                    n_first_addr = '0;
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase = PH_AFIX;
                                end
                            end
                        end else if (rem <= L'(b) + L'(1)) begin
                            n_phase = PH_DONE;
                            if (n_in_ans) n_first_addr = '0; else n_err = 1'b1;
                        end else begin
                            nl = 10'(n_name_len) + 10'(n_name_len != 8'd0) + 10'(b);
                            if (!n_in_ans && n_first_q && nl > 10'(r_name_limit)) begin
                                n_err = 1'b1;
                                n_phase = PH_DONE;
                            end else begin
                                if (!n_in_ans && n_first_q) n_name_len = nl[7:0];
                                n_label_left = b;
                                n_phase = PH_LABEL;
                            end
                        end
                    end
                    PH_LABEL: begin
                        n_label_left = n_label_left - 8'd1;
                        if (n_label_left == 8'd0) n_phase = PH_NAME;
                    end
                    PH_PTR: begin
                        n_sub = '0;
                        n_shift = '0;
                        if (!n_in_ans) begin
                            if (after < L'(4)) begin
                                n_err = 1'b1;
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_QTAIL;
                            end
                        end else if (after < L'(10)) begin
                            n_first_addr = '0;
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_AFIX;
                        end
                    end
                    PH_QTAIL: begin
                        n_sub = n_sub + 4'd1;
                        if (n_sub >= 4'd4) begin
                            n_q_left = n_q_left - 16'd1;
                            n_first_q = 1'b0;
                            nx = f_next_question(n_q_left == '0, start_ok, n_a_left == '0,
                                                 n_stored >= r_max_addresses, after_zero);
                            n_phase = nx.phase;
                            if (nx.set_err) n_err = 1'b1;
                            if (nx.set_in_ans) n_in_ans = 1'b1;
                            if (nx.clr_addr) n_first_addr = '0;
                        end
                    end
                    PH_AFIX: begin
                        if (n_sub == 4'd9) begin
                            len = n_shift[15:0];
                            if (17'(after) < 17'(len)) begin
                                n_first_addr = '0;
                                n_phase = PH_DONE;
                            end else begin
                                n_rec_is_a = (n_rec_type == 16'd1) && (len == 16'd4);
                                n_rdl = len;
                                if (len == 16'd0) begin
                                    n_a_left = n_a_left - 16'd1;
                                    nx = f_next_answer(n_a_left == '0,
                                                       n_stored >= r_max_addresses,
                                                       after_zero);
                                    n_phase = nx.phase;
                                    if (nx.clr_addr) n_first_addr = '0;
                                end else begin
                                    n_phase = PH_ADATA;
                                end
                            end
                        end else begin
                            if (n_sub == 4'd1) n_rec_type = n_shift[15:0];
                            if (n_sub == 4'd7) n_rec_ttl = n_shift;
                            n_sub = n_sub + 4'd1;
                        end
                    end
                    PH_ADATA: begin
                        n_rdl = n_rdl - 16'd1;
                        if (n_rdl == 16'd0) begin
                            if (n_rec_is_a) begin
                                rec_res = '{result_kind: dre_pkg::KindRecord,
                                            address: n_shift, ttl: n_rec_ttl,
                                            status: dre_pkg::StatusOk, last: 1'b0};
                                push.count = 2'd1;
                                push.entry0 = rec_res;
                                n_stored = n_stored + 5'd1;
                                if (n_first_addr == '0) n_first_addr = n_shift;
                            end
                            n_a_left = n_a_left - 16'd1;
                            nx = f_next_answer(n_a_left == '0, n_stored >= r_max_addresses,
                                               after_zero);
                            n_phase = nx.phase;
                            if (nx.clr_addr) n_first_addr = '0;
                        end
                    end
                    default: ;
                endcase

                n_offset = n_offset + L'(1);
                if (n_offset == n_total) begin
                    // Last payload byte: close the reply with a summary.
                    if (n_err) begin
                        st = dre_pkg::StatusError;
                    end else if (!n_exp || n_first_addr == '0) begin
                        st = dre_pkg::StatusNone;
                    end else begin
                        st = dre_pkg::StatusOk;
                    end
                    sum_res = '{result_kind: dre_pkg::KindSummary,
                                address: (st == dre_pkg::StatusOk) ? n_first_addr : 32'd0,
                                ttl: 32'd0, status: st, last: 1'b1};
                    push_sum = 1'b1;
                    n_phase = PH_IDLE;
                end
            end

            if (push_sum) begin
                if (push.count == 2'd1) begin
                    push.count = 2'd2;
                    push.entry1 = sum_res;
                end else begin
                    push.count = 2'd1;
                    push.entry0 = sum_res;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_offset <= '0; r_total <= '0; r_exp <= 1'b0;
            r_flags <= '0; r_q_left <= '0; r_a_left <= '0; r_label_left <= '0;
            r_name_len <= '0; r_shift <= '0; r_rdl <= '0; r_stored <= '0;
            r_first_addr <= '0; r_err <= 1'b0; r_in_ans <= 1'b0; r_first_q <= 1'b0;
            r_rec_is_a <= 1'b0; r_sub <= '0; r_rec_type <= '0; r_rec_ttl <= '0;
        end else begin
            r_phase <= n_phase; r_offset <= n_offset; r_total <= n_total; r_exp <= n_exp;
            r_flags <= n_flags; r_q_left <= n_q_left; r_a_left <= n_a_left;
            r_label_left <= n_label_left; r_name_len <= n_name_len; r_shift <= n_shift;
            r_rdl <= n_rdl; r_stored <= n_stored; r_first_addr <= n_first_addr;
            r_err <= n_err; r_in_ans <= n_in_ans; r_first_q <= n_first_q;
            r_rec_is_a <= n_rec_is_a; r_sub <= n_sub; r_rec_type <= n_rec_type;
            r_rec_ttl <= n_rec_ttl;
        end
    end

    dre_rfifo u_rfifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space2 (space2),
        .o_res    (o_res)
    );

    // A beat outside any reply produces nothing.
    `DRE_ASSERT_NOW(a_idle_silent, i_clk, i_rst_n, acc && !i_req.first_byte && r_phase == PH_IDLE, push.count == 2'd0)
    // Two results in one cycle only when a record and the summary coincide.
    `DRE_ASSERT_NOW(a_two_push, i_clk, i_rst_n, push.count == 2'd2, push_sum && push.entry0.result_kind == dre_pkg::KindRecord)
    // The summary always returns the parser to idle.
    `DRE_ASSERT_NEXT(a_sum_idle, i_clk, i_rst_n, push_sum, r_phase == PH_IDLE)
endmodule
